// ===== rtl/kqie_pkg.sv =====
// Shared types, constants and register codes for the keyed quoted integer extractor.
// No dependencies; all other files but kqie_checker use this package.
`default_nettype none

package kqie_pkg;

   localparam int MAX_KEY_BYTES_DEFAULT = 16;
   localparam int KEY_REG_BYTES         = 16;
   localparam int KEY_LEN_W             = 5;
   localparam int VALUE_W               = 16;
   localparam int MAG_W                 = 17;
   localparam int CSR_INDEX_W           = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWEST     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGHEST    = 3'd4;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [KEY_LEN_W-1:0]      KEY_LENGTH_RESET = 5'd1;
   localparam logic signed [VALUE_W-1:0] LOWEST_RESET     = -16'sd99;
   localparam logic signed [VALUE_W-1:0] HIGHEST_RESET    = 16'sd99;

   typedef struct packed {
      logic [63:0]                 key_first_bytes;
      logic [63:0]                 key_second_bytes;
      logic [KEY_LEN_W-1:0]        key_length;
      logic signed [VALUE_W-1:0]   lowest_value;
      logic signed [VALUE_W-1:0]   highest_value;
   } cfg_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctl_type;

   typedef struct packed {
      logic match;
      logic key_empty;
   } win_sts_type;

   typedef enum logic [3:0] {
      PH_SEARCH = 4'b0001,
      PH_SIGN   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

endpackage

`default_nettype wire

// ===== rtl/kqie_csr.sv =====
// Configuration register file: key bytes, key length and value bounds.
// Depends on kqie_pkg.
`default_nettype none

module kqie_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [kqie_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]                      csr_wdata,
   output kqie_pkg::cfg_type                     cfg
);
   import kqie_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY_FIRST:  cfg_in.key_first_bytes  = csr_wdata;
            CSR_KEY_SECOND: cfg_in.key_second_bytes = csr_wdata;
            CSR_KEY_LENGTH: cfg_in.key_length       = csr_wdata[KEY_LEN_W-1:0];
            CSR_LOWEST:     cfg_in.lowest_value     = $signed(csr_wdata[VALUE_W-1:0]);
            CSR_HIGHEST:    cfg_in.highest_value    = $signed(csr_wdata[VALUE_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_first_bytes  <= '0;
         cfg_ff.key_second_bytes <= '0;
         cfg_ff.key_length       <= KEY_LENGTH_RESET;
         cfg_ff.lowest_value     <= LOWEST_RESET;
         cfg_ff.highest_value    <= HIGHEST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/kqie_window.sv =====
// Sliding window of recent text bytes and the key comparator.
// Depends on kqie_pkg.
`default_nettype none

module kqie_window #(
   parameter int MAX_KEY_BYTES = kqie_pkg::MAX_KEY_BYTES_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  kqie_pkg::cfg_type         cfg,
   input  kqie_pkg::win_ctl_type     ctl,
   input  wire logic [7:0]           text_byte,
   output kqie_pkg::win_sts_type     sts
);
   import kqie_pkg::*;

   localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
   localparam int IDX_W  = $clog2(MAX_KEY_BYTES);
   localparam int KLEN_W = KEY_LEN_W + 1;

   logic [7:0]       win_ff    [MAX_KEY_BYTES];
   logic [7:0]       win_shift [MAX_KEY_BYTES];
   logic [7:0]       key_arr   [MAX_KEY_BYTES];
   logic [CNT_W-1:0] seen_ff;
   logic [CNT_W-1:0] seen_in;
   logic [CNT_W-1:0] len;
   logic [KLEN_W-1:0] key_len_ext;
   logic [MAX_KEY_BYTES-1:0] pos_ok;

   assign key_len_ext = {1'b0, cfg.key_length};
   assign len = (key_len_ext > KLEN_W'(MAX_KEY_BYTES)) ? CNT_W'(MAX_KEY_BYTES)
                                                       : CNT_W'(key_len_ext);

   assign win_shift[0] = text_byte;
   assign seen_in = (seen_ff == CNT_W'(MAX_KEY_BYTES)) ? seen_ff : seen_ff + CNT_W'(1);

   for (genvar j = 0; j < MAX_KEY_BYTES; j++) begin : g_pos
      logic [CNT_W-1:0] kidx;

      if (j > 0) begin : g_tap
         assign win_shift[j] = win_ff[j-1];
      end

      if (j < 8) begin : g_key_lo
         assign key_arr[j] = cfg.key_first_bytes[8*j +: 8];
      end else if (j < KEY_REG_BYTES) begin : g_key_hi
         assign key_arr[j] = cfg.key_second_bytes[8*(j-8) +: 8];
      end else begin : g_key_none
         assign key_arr[j] = CHAR_NUL;
      end

      assign kidx      = len - CNT_W'(j) - CNT_W'(1);
      assign pos_ok[j] = (CNT_W'(j) >= len) || (win_shift[j] == key_arr[kidx[IDX_W-1:0]]);
   end

   assign sts.match     = (seen_in >= len) && (&pos_ok);
   assign sts.key_empty = (len == '0);

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         win_ff <= win_shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         seen_ff <= '0;
      end else if (ctl.shift) begin
         seen_ff <= seen_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/kqie_core.sv =====
// Per-byte parser: phase control, sign, digit accumulation, bound checks and decision.
// Depends on kqie_pkg; drives the window controls.
`default_nettype none

module kqie_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              step,
   input  wire logic [7:0]                        text_byte,
   input  wire logic                              last_byte,
   input  kqie_pkg::cfg_type                      cfg,
   input  kqie_pkg::win_sts_type                  win_sts,
   output kqie_pkg::win_ctl_type                  win_ctl,
   output logic                                   emit,
   output logic                                   emit_ok,
   output logic [kqie_pkg::VALUE_W-1:0]           emit_value
);
   import kqie_pkg::*;

   localparam int AW = 22;

   phase_type        phase_ff, phase_in;
   logic             minus_ff, minus_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic             digit_ff, digit_in;

   logic                 is_nul, sign_act, dig_act, minus_n, over;
   logic [7:0]           d8;
   logic signed [AW-1:0] lo_w, hi_w, lim_w, d_w, m_w, x_w, acc_w, v_w;

   assign lo_w = {{(AW-VALUE_W){cfg.lowest_value[VALUE_W-1]}}, cfg.lowest_value};
   assign hi_w = {{(AW-VALUE_W){cfg.highest_value[VALUE_W-1]}}, cfg.highest_value};
   assign m_w  = $signed({{(AW-MAG_W){1'b0}}, mag_ff});
   assign d8   = text_byte - CHAR_ZERO;
   assign d_w  = $signed({{(AW-8){1'b0}}, d8});
   assign is_nul = (text_byte == CHAR_NUL);

   always_comb begin
      phase_in    = phase_ff;
      minus_in    = minus_ff;
      mag_in      = mag_ff;
      digit_in    = digit_ff;
      win_ctl     = '0;
      emit        = 1'b0;
      emit_ok     = 1'b0;
      emit_value  = '0;
      sign_act    = 1'b0;
      dig_act     = 1'b0;
      minus_n     = minus_ff;
      lim_w       = '0;
      x_w         = '0;
      acc_w       = '0;
      v_w         = '0;
      over        = 1'b0;

      if (step) begin
         case (phase_ff)
            PH_SEARCH: begin
               if (is_nul) begin
                  emit = 1'b1;
                  phase_in = PH_DONE;
               end else if (win_sts.key_empty) begin
                  sign_act = 1'b1;
               end else begin
                  win_ctl.shift = 1'b1;
                  if (win_sts.match) begin
                     phase_in = PH_SIGN;
                  end
               end
            end
            PH_SIGN: begin
               if (is_nul) begin
                  emit = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  sign_act = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (is_nul) begin
                  emit = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  dig_act = 1'b1;
               end
            end
            PH_DONE: ;
            default: ;
         endcase

         if (sign_act) begin
            minus_n  = (text_byte == CHAR_MINUS);
            minus_in = minus_n;
         end
         lim_w = minus_n ? -lo_w : hi_w;

         if (sign_act) begin
            if (lim_w < 0) begin
               emit     = 1'b1;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_DIGITS;
               dig_act  = !minus_n;
            end
         end

         if (dig_act) begin
            if (text_byte >= CHAR_ZERO && text_byte <= CHAR_NINE) begin
               x_w   = lim_w - d_w;
               acc_w = (m_w <<< 3) + (m_w <<< 1) + d_w;
               // truncating divide: for negative x only a zero magnitude with x > -10 passes
               over  = (x_w >= 0) ? (acc_w > lim_w)
                                  : ((mag_ff != '0) || (x_w <= -22'sd10));
               if (over) begin
                  emit     = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  mag_in   = acc_w[MAG_W-1:0];
                  digit_in = 1'b1;
               end
            end else if (digit_ff && text_byte == CHAR_QUOTE) begin
               v_w      = minus_n ? -m_w : m_w;
               emit     = 1'b1;
               phase_in = PH_DONE;
               if (v_w >= lo_w && v_w <= hi_w) begin
                  emit_ok    = 1'b1;
                  emit_value = v_w[VALUE_W-1:0];
               end
            end else begin
               emit     = 1'b1;
               phase_in = PH_DONE;
            end
         end

         if (last_byte) begin
            if (phase_in != PH_DONE) begin
               emit = 1'b1;
            end
            phase_in      = PH_SEARCH;
            minus_in      = 1'b0;
            mag_in        = '0;
            digit_in      = 1'b0;
            win_ctl.clear = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         minus_ff <= 1'b0;
         mag_ff   <= '0;
         digit_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         minus_ff <= minus_in;
         mag_ff   <= mag_in;
         digit_ff <= digit_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/keyed_quoted_integer_extractor.sv =====
// Top level of the keyed quoted integer extractor: input register, parser, result register.
// Depends on kqie_pkg, kqie_csr, kqie_window and kqie_core.
//
//   channel | dir | ports                                  | payload
//   req     | in  | req_tvalid/tready/tdata/tlast          | tdata[7:0] text_byte, tlast last_byte
//   rsp     | out | rsp_tvalid/tready/tdata/tuser          | tdata[15:0] parsed_value, tuser parse_ok
//   csr     | in  | csr_valid/ready/index/wdata            | register index, write data
//
// One byte per cycle unless the result stalls; input bytes and results are both registered.
// The per-byte window compare and the multiply-by-ten accumulate set the cycle time.
// Synchronous reset clears all message state and restores register defaults.
// A stalled result holds the parser whenever a byte is waiting; the input stalls once the
// input register is also full.
`default_nettype none

module keyed_quoted_integer_extractor #(
   parameter int MAX_KEY_BYTES = kqie_pkg::MAX_KEY_BYTES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,   // [7:0] text_byte
   input  wire logic                             req_tlast,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [15:0]                           rsp_tdata,   // [15:0] parsed_value
   output logic [0:0]                            rsp_tuser,   // [0] parse_ok
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [kqie_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]                      csr_wdata
);
   import kqie_pkg::*;

   cfg_type     cfg;
   win_ctl_type win_ctl;
   win_sts_type win_sts;

   logic               in_vld_ff, in_vld_in;
   logic [7:0]         in_byte_ff;
   logic               in_last_ff;
   logic               out_vld_ff, out_vld_in;
   logic               out_ok_ff;
   logic [VALUE_W-1:0] out_value_ff;
   logic               step, emit, emit_ok;
   logic [VALUE_W-1:0] emit_value;

   assign step       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || step;
   assign in_vld_in  = (req_tvalid && req_tready) ? 1'b1 : (step ? 1'b0 : in_vld_ff);
   assign out_vld_in = (step && emit) ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

   assign rsp_tvalid   = out_vld_ff;
   assign rsp_tdata    = out_value_ff;
   assign rsp_tuser[0] = out_ok_ff;

   kqie_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kqie_window #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ctl       (win_ctl),
      .text_byte (in_byte_ff),
      .sts       (win_sts)
   );

   kqie_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .text_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .cfg        (cfg),
      .win_sts    (win_sts),
      .win_ctl    (win_ctl),
      .emit       (emit),
      .emit_ok    (emit_ok),
      .emit_value (emit_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step && emit) begin
         out_ok_ff    <= emit_ok;
         out_value_ff <= emit_value;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/kqie_checker.sv =====
// Port-level checker for keyed_quoted_integer_extractor, attached by bind.
// Watches the request ready and the result channel only.
`default_nettype none

module kqie_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   // a failed parse carries a zero value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == 16'h0000))
      else $error("failed result with nonzero value");

   // nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a byte is taken whenever the result side can move
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while result side free");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind keyed_quoted_integer_extractor kqie_checker u_kqie_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
